FILE: design/erle_pkg.sv
package erle_pkg;

	localparam logic [7:0]  ESC_BYTE    = 8'hED;
	localparam logic [16:0] MODE0_START = 17'h04000;
	localparam logic [16:0] MODE1_START = 17'h0C000;
	localparam logic [16:0] ADDR_LIMIT  = 17'h10000;
	localparam logic [15:0] RAW_LENGTH  = 16'hFFFF;
	localparam logic [2:0]  RUN_TAKE    = 3'd4;
	localparam logic [2:0]  WIN_DEPTH   = 3'd4;
	localparam logic [1:0]  FIFO_DEPTH  = 2'd2;

	typedef enum logic [1:0] {
		REG_FORMAT_MODE  = 2'd0,
		REG_BLOCK_LENGTH = 2'd1,
		REG_TARGET_BANK  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		PH_DECODE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ACT_LITERAL,
		ACT_RUN,
		ACT_MARKER,
		ACT_WAIT
	} act_t;

	typedef struct packed {
		logic [7:0] value;
		logic       esc;
		logic       zero;
	} byte_tok_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] block_length;
		logic [2:0]  bank;
	} erle_cfg_t;

endpackage

FILE: design/erle_channels.sv
interface erle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface erle_run_if;
	logic        valid;
	logic        ready;
	logic [15:0] start_address;
	logic [7:0]  fill_value;
	logic [7:0]  run_length;
	logic [2:0]  bank_out;
	logic        block_done;
	logic        overflow_error;

	modport source(output valid, output start_address, output fill_value, output run_length,
		output bank_out, output block_done, output overflow_error, input ready);
	modport sink(input valid, input start_address, input fill_value, input run_length,
		input bank_out, input block_done, input overflow_error, output ready);
endinterface

interface erle_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/ed_escape_rle_decoder_unit.sv
// path: a literal byte passes the input queue, then the result register, to reach
// runs; so does a run after its value byte, and the end marker after its last byte
// throughput: one byte per cycle while runs is ready, set by the single decode step
// per cycle and one-entry result register; released held bytes give one run per cycle
// reset: all control state cleared, mode 0 with address 0x4000; a write to format_mode
// or block_length restarts decoding in the cycle after the write
module ed_escape_rle_decoder_unit import erle_pkg::*; #(
	parameter int unsigned BANK_SIZE = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	erle_byte_if.sink  stream,
	erle_run_if.source runs,
	erle_cfg_if.sink   cfg
);

	erle_cfg_t cfg_q;
	logic      restart_q;
	logic      cfg_wr;
	byte_tok_t head;
	logic      head_valid;
	logic      pop;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= '0;
			restart_q <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg.index)
					REG_FORMAT_MODE: begin
						cfg_q.mode <= cfg.data[0];
						restart_q  <= 1'b1;
					end
					REG_BLOCK_LENGTH: begin
						cfg_q.block_length <= cfg.data;
						restart_q          <= 1'b1;
					end
					REG_TARGET_BANK: begin
						cfg_q.bank <= cfg.data[2:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	erle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	erle_back #(
		.BANK_SIZE (BANK_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.restart    (restart_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.runs       (runs)
	);

endmodule

FILE: design/erle_front.sv
module erle_front import erle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	erle_byte_if.sink stream,
	output byte_tok_t head,
	output logic      head_valid,
	input  logic      pop
);

	byte_tok_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	byte_tok_t  tok;

	assign stream.ready = (count_q != FIFO_DEPTH);
	assign push         = stream.valid && stream.ready;
	assign head_valid   = (count_q != 2'd0);
	assign head         = mem_q[rd_ptr_q];

	// classify once on the way in
	always_comb begin
		tok.value = stream.in_byte;
		tok.esc   = (stream.in_byte == ESC_BYTE);
		tok.zero  = (stream.in_byte == 8'h00);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: design/erle_back.sv
module erle_back import erle_pkg::*; #(
	parameter int unsigned BANK_SIZE = 16384
) (
	input  logic       clk,
	input  logic       arst_n,
	input  erle_cfg_t  cfg,
	input  logic       restart,
	input  byte_tok_t  head,
	input  logic       head_valid,
	output logic       pop,
	erle_run_if.source runs
);

	localparam logic [16:0] BANK_TOTAL = 17'(BANK_SIZE);

	phase_t      phase_q, phase_nx;
	byte_tok_t   buf_q [4];
	logic [2:0]  cnt_q;
	logic [16:0] addr_q;
	logic [16:0] consumed_q;

	logic        res_valid_q;
	logic [15:0] res_addr_q;
	logic [7:0]  res_val_q;
	logic [7:0]  res_len_q;
	logic [2:0]  res_bank_q;
	logic        res_done_q;
	logic        res_err_q;

	byte_tok_t   w [4];
	logic        raw, empty_blk, use_head, rem_ge4, match, decoding, slot_free;
	logic [16:0] total;
	logic [2:0]  wcnt, take;
	act_t        esc_act, act;
	logic [7:0]  run_len, run_val;
	logic [16:0] consumed_nx, end_sum;
	logic        done, ovf, is_marker;
	logic        do_empty, do_append, decide, emit_req, fire_step, finish, discard;
	logic        res_load, res_done_nx, res_err_nx;
	logic [7:0]  res_val_nx, res_len_nx;

	// window: held bytes followed by the queue head
	always_comb begin
		raw       = cfg.mode && (cfg.block_length == RAW_LENGTH);
		total     = raw ? BANK_TOTAL : {1'b0, cfg.block_length};
		empty_blk = cfg.mode && (total == 17'd0);
		use_head  = head_valid && (cnt_q != WIN_DEPTH);
		wcnt      = cnt_q + {2'b00, use_head};
		for (int i = 0; i < 4; i++) begin
			w[i] = (3'(i) < cnt_q) ? buf_q[i] : head;
		end
		rem_ge4 = ({1'b0, consumed_q} + 18'd4) <= {1'b0, total};

		if (wcnt < 3'd2) begin
			esc_act = ACT_WAIT;
		end else if (!w[1].esc) begin
			esc_act = ACT_LITERAL;
		end else if (wcnt < 3'd4) begin
			esc_act = ACT_WAIT;
		end else begin
			esc_act = ACT_RUN;
		end

		match = (wcnt < 3'd2 || w[1].esc) && (wcnt < 3'd3 || w[2].esc) &&
			(wcnt < 3'd4 || w[3].zero);

		act = ACT_LITERAL;
		if (cfg.mode) begin
			if (!raw && w[0].esc && rem_ge4) begin
				act = esc_act;
			end
		end else if (w[0].zero) begin
			if (match) begin
				act = (wcnt < 3'd4) ? ACT_WAIT : ACT_MARKER;
			end
		end else if (w[0].esc) begin
			act = esc_act;
		end

		take        = (act == ACT_RUN) ? RUN_TAKE : 3'd1;
		run_len     = (act == ACT_RUN) ? w[2].value : 8'd1;
		run_val     = (act == ACT_RUN) ? w[3].value : w[0].value;
		consumed_nx = consumed_q + {14'd0, take};
		done        = cfg.mode && (consumed_nx >= total);
		end_sum     = addr_q + {9'd0, run_len};
		is_marker   = (act == ACT_MARKER);
		ovf         = !is_marker && (run_len != 8'd0) && (end_sum > ADDR_LIMIT);

		decoding  = (phase_q == PH_DECODE);
		slot_free = !res_valid_q || runs.ready;
		do_empty  = !restart && decoding && empty_blk && use_head && slot_free;
		do_append = !restart && decoding && !empty_blk && (wcnt != 3'd0) &&
			(act == ACT_WAIT) && use_head;
		decide    = !restart && decoding && !empty_blk && (wcnt != 3'd0) && (act != ACT_WAIT);
		emit_req  = is_marker || ovf || (run_len != 8'd0) || done;
		fire_step = decide && (!emit_req || slot_free);
		finish    = is_marker || ovf || done;
		discard   = !restart && !decoding && head_valid;

		pop = do_empty || do_append || (fire_step && use_head) || discard;
	end

	always_comb begin
		phase_nx = phase_q;
		if (restart) begin
			phase_nx = PH_DECODE;
		end else if (do_empty || (fire_step && finish)) begin
			phase_nx = PH_DONE;
		end
	end

	// result fields
	always_comb begin
		res_load    = do_empty || (fire_step && emit_req);
		res_done_nx = do_empty || finish;
		res_err_nx  = !do_empty && ovf;
		res_val_nx  = (do_empty || is_marker) ? 8'd0 : run_val;
		res_len_nx  = (do_empty || is_marker) ? 8'd0 : run_len;
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			buf_q[cnt_q[1:0]] <= head;
		end else if (fire_step) begin
			for (int i = 0; i < 3; i++) begin
				buf_q[i] <= w[i + 1];
			end
		end
		if (res_load) begin
			res_addr_q <= addr_q[15:0];
			res_val_q  <= res_val_nx;
			res_len_q  <= res_len_nx;
			res_bank_q <= cfg.bank;
			res_done_q <= res_done_nx;
			res_err_q  <= res_err_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DECODE;
			cnt_q       <= 3'd0;
			addr_q      <= MODE0_START;
			consumed_q  <= 17'd0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			if (restart) begin
				cnt_q      <= 3'd0;
				consumed_q <= 17'd0;
				addr_q     <= cfg.mode ? MODE1_START : MODE0_START;
			end else if (do_append) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (fire_step) begin
				cnt_q <= finish ? 3'd0 : (wcnt - take);
				if (cfg.mode) begin
					consumed_q <= consumed_nx;
				end
				if (!is_marker && !ovf) begin
					addr_q <= end_sum;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (runs.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign runs.valid          = res_valid_q;
	assign runs.start_address  = res_addr_q;
	assign runs.fill_value     = res_val_q;
	assign runs.run_length     = res_len_q;
	assign runs.bank_out       = res_bank_q;
	assign runs.block_done     = res_done_q;
	assign runs.overflow_error = res_err_q;

	a_win_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= WIN_DEPTH)
		else $error("lookahead window over capacity");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> cnt_q == 3'd0)
		else $error("held bytes left after end of block");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res_done_nx |=> phase_q == PH_DONE)
		else $error("final run issued but decoding goes on");

	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q <= ADDR_LIMIT)
		else $error("write address past top of memory");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

FILE: tb/sv/ed_escape_rle_decoder_unit_tb.sv
module ed_escape_rle_decoder_unit_tb import erle_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BANK_SIZE = 16384;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int unsigned RANDOM_BYTES = 60;
	localparam int unsigned RAW_BYTES = 16;

	typedef struct packed {
		logic [15:0] start_address;
		logic [7:0]  fill_value;
		logic [7:0]  run_length;
		logic [2:0]  bank_out;
		logic        block_done;
		logic        overflow_error;
	} run_t;

	// tracks decoder state and holds the runs still due from the block
	class decoded_runs;
		bit          mode;
		logic [15:0] blen;
		logic [2:0]  bank;
		phase_t      phase;
		bit [7:0]    held [3];
		int unsigned pend;
		int unsigned addr;
		int unsigned consumed;
		run_t        due_runs[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			mode = 1'b0;
			blen = '0;
			bank = '0;
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_DECODE;
			foreach (held[i]) held[i] = '0;
			pend = 0;
			consumed = 0;
			addr = mode ? MODE1_START : MODE0_START;
		endfunction

		function void apply_reg(logic [1:0] idx, logic [15:0] d);
			case (idx)
				REG_FORMAT_MODE: begin
					mode = d[0];
					restart();
				end
				REG_BLOCK_LENGTH: begin
					blen = d;
					restart();
				end
				REG_TARGET_BANK: begin
					bank = d[2:0];
				end
				default: ;
			endcase
		endfunction

		function void emit(logic [7:0] val, int unsigned len, bit done, bit err);
			run_t r;
			r.start_address = addr[15:0];
			r.fill_value = val;
			r.run_length = len[7:0];
			r.bank_out = bank;
			r.block_done = done;
			r.overflow_error = err;
			due_runs.push_back(r);
		endfunction

		function void decode_byte(logic [7:0] b);
			bit [7:0]    win [4];
			int unsigned total, cnt, pos, avail, remaining, take, run_len;
			logic [7:0]  run_val, b0;
			bit          is_raw, done, is_marker;
			if (phase != PH_DECODE) return;
			is_raw = mode && (blen == RAW_LENGTH);
			total = is_raw ? BANK_SIZE : int'(blen);
			// empty block ends on the first byte without using it
			if (mode && total == 0) begin
				emit(8'h00, 0, 1'b1, 1'b0);
				phase = PH_DONE;
				return;
			end
			cnt = (pend > 3) ? 3 : pend;
			for (int i = 0; i < 4; i++) win[i] = '0;
			for (int i = 0; i < cnt; i++) win[i] = held[i];
			win[cnt] = b;
			cnt++;
			pos = 0;
			while (pos < cnt) begin
				avail = cnt - pos;
				b0 = win[pos];
				take = 1;
				run_len = 1;
				run_val = b0;
				if (mode) begin
					remaining = (total > consumed) ? total - consumed : 0;
					// last three block bytes are always literals
					if (!is_raw && b0 == ESC_BYTE && remaining >= 4) begin
						if (avail < 2) break;
						if (win[pos + 1] == ESC_BYTE) begin
							if (avail < 4) break;
							take = 4;
							run_len = win[pos + 2];
							run_val = win[pos + 3];
						end
					end
				end else if (b0 == 8'h00) begin
					is_marker = (avail < 2 || win[pos + 1] == ESC_BYTE) &&
						(avail < 3 || win[pos + 2] == ESC_BYTE) &&
						(avail < 4 || win[pos + 3] == 8'h00);
					if (is_marker && avail < 4) break;
					if (is_marker) begin
						emit(8'h00, 0, 1'b1, 1'b0);
						phase = PH_DONE;
						pend = 0;
						return;
					end
				end else if (b0 == ESC_BYTE) begin
					if (avail < 2) break;
					if (win[pos + 1] == ESC_BYTE) begin
						if (avail < 4) break;
						take = 4;
						run_len = win[pos + 2];
						run_val = win[pos + 3];
					end
				end
				pos += take;
				if (mode) consumed += take;
				done = mode && (consumed >= total);
				if (run_len > 0 && addr + run_len > ADDR_LIMIT) begin
					emit(run_val, run_len, 1'b1, 1'b1);
					phase = PH_DONE;
					pend = 0;
					return;
				end
				if (run_len > 0 || done) begin
					emit(run_val, run_len, done, 1'b0);
					addr += run_len;
				end
				if (done) begin
					phase = PH_DONE;
					pend = 0;
					return;
				end
			end
			pend = cnt - pos;
			foreach (held[i]) held[i] = '0;
			for (int i = 0; i < pend && i < 3; i++) held[i] = win[pos + i];
		endfunction

		function void cmp(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void match_run(run_t got);
			run_t want;
			checked++;
			if (due_runs.size() == 0) begin
				$error("run at %0h with nothing expected", got.start_address);
				errors++;
				return;
			end
			want = due_runs.pop_front();
			cmp("start_address", want.start_address, got.start_address);
			cmp("fill_value", want.fill_value, got.fill_value);
			cmp("run_length", want.run_length, got.run_length);
			cmp("bank_out", want.bank_out, got.bank_out);
			cmp("block_done", want.block_done, got.block_done);
			cmp("overflow_error", want.overflow_error, got.overflow_error);
		endfunction

		function int unsigned outstanding();
			return due_runs.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	erle_byte_if byte_ch();
	erle_run_if  run_ch();
	erle_cfg_if  reg_ch();

	ed_escape_rle_decoder_unit #(.BANK_SIZE(BANK_SIZE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(byte_ch),
		.runs(run_ch),
		.cfg(reg_ch)
	);

	decoded_runs book = new();
	bit          no_stall = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned phases = 0;
	int unsigned idle_cycles = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (no_stall) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic offer_byte(logic [7:0] b);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			byte_ch.valid <= 1'b0;
		end
		@(negedge clk);
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		book.decode_byte(b);
		bytes_sent++;
	endtask

	task automatic send_bytes(logic [7:0] q[$]);
		foreach (q[i]) offer_byte(q[i]);
		@(negedge clk);
		byte_ch.valid <= 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] wdata);
		@(negedge clk);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data <= wdata;
		do @(posedge clk); while (!reg_ch.ready);
		book.apply_reg(idx, wdata);
		reg_writes++;
		@(negedge clk);
		reg_ch.valid <= 1'b0;
	endtask

	// idle point: every due run seen, then room for held bytes still in flight
	task automatic drain();
		while (book.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(bit m, logic [15:0] len, logic [2:0] bk);
		logic [15:0] d;
		drain();
		d = 16'($urandom);
		d[2:0] = bk;
		write_reg(REG_TARGET_BANK, d);
		d = 16'($urandom);
		d[0] = m;
		write_reg(REG_FORMAT_MODE, d);
		write_reg(REG_BLOCK_LENGTH, len);
		if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, 16'($urandom));
		// decoding restarts in the cycle after the write
		repeat (2) @(negedge clk);
		phases++;
	endtask

	function automatic logic [7:0] not_esc();
		logic [7:0] x;
		x = 8'($urandom_range(0, 254));
		if (x >= ESC_BYTE) x++;
		return x;
	endfunction

	function automatic void add_piece(ref logic [7:0] q[$]);
		int r, c;
		logic [7:0] x;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			q.push_back(8'($urandom_range(0, 255)));
		end else if (r < 75) begin
			c = $urandom_range(0, 9);
			q.push_back(ESC_BYTE);
			q.push_back(ESC_BYTE);
			if (c == 0) q.push_back(8'h00);
			else if (c == 1) q.push_back(8'hFF);
			else if (c == 2) q.push_back(8'h01);
			else q.push_back(8'($urandom_range(2, 20)));
			q.push_back(8'($urandom_range(0, 255)));
		end else if (r < 85) begin
			// lone escape byte
			q.push_back(ESC_BYTE);
			q.push_back(not_esc());
		end else if (r < 95) begin
			// broken end marker
			q.push_back(8'h00);
			q.push_back(ESC_BYTE);
			if ($urandom_range(0, 1) == 0) begin
				q.push_back(not_esc());
			end else begin
				q.push_back(ESC_BYTE);
				x = 8'($urandom_range(1, 255));
				q.push_back(x);
			end
		end else begin
			repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// result channel back-pressure
	initial begin
		int n;
		run_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = pick_gap();
			repeat (n) begin
				@(negedge clk);
				run_ch.ready <= 1'b0;
			end
			n = $urandom_range(1, 10);
			repeat (n) begin
				@(negedge clk);
				run_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && run_ch.valid && run_ch.ready) begin
			book.match_run({run_ch.start_address, run_ch.fill_value, run_ch.run_length,
				run_ch.bank_out, run_ch.block_done, run_ch.overflow_error});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (run_ch.valid && run_ch.ready) ||
					(reg_ch.valid && reg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0]  q[$];
		int unsigned random_bytes;
		int unsigned lim;
		int          r;
		bit          m;
		logic [15:0] len;
		logic [2:0]  bk;

		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		reg_ch.valid = 1'b0;
		reg_ch.index = '0;
		reg_ch.data = '0;
		random_bytes = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: literals, lone escape, held run across a bank write
		q = '{8'hFF, 8'h00, 8'h7F, ESC_BYTE, 8'h01, ESC_BYTE, ESC_BYTE, 8'h05};
		send_bytes(q);
		drain();
		write_reg(REG_TARGET_BANK, 16'h0005);
		write_reg(REG_NONE, 16'hFFFF);
		// run value, zero count run, end marker, ignored byte
		q = '{8'hAA, ESC_BYTE, ESC_BYTE, 8'h00, 8'h33, 8'h00, ESC_BYTE, ESC_BYTE, 8'h00, 8'h5A};
		send_bytes(q);

		// empty block then a byte after the end
		configure(1'b1, 16'h0000, 3'd7);
		q = '{8'h3C, 8'h99};
		send_bytes(q);

		// run followed by an escape byte in the literal tail
		configure(1'b1, 16'd5, 3'd0);
		q = '{ESC_BYTE, ESC_BYTE, 8'h02, 8'h11, ESC_BYTE};
		send_bytes(q);

		while (random_bytes < RANDOM_BYTES) begin
			m = 1'($urandom_range(0, 1));
			bk = 3'($urandom_range(0, 7));
			r = $urandom_range(0, 99);
			if (r < 8) len = 16'd0;
			else if (r < 20) len = 16'($urandom_range(1, 4));
			else if (r < 28) len = 16'hFFFE;
			else len = 16'($urandom_range(5, 40));
			no_stall = ($urandom_range(0, 4) == 0);
			configure(m, len, bk);
			q.delete();
			if (!m) begin
				repeat ($urandom_range(3, 12)) add_piece(q);
				if ($urandom_range(0, 4) != 0) begin
					q.push_back(8'h00);
					q.push_back(ESC_BYTE);
					q.push_back(ESC_BYTE);
					q.push_back(8'h00);
				end
			end else begin
				lim = (len == 16'hFFFE) ? 30 : ((len == 0) ? 1 : int'(len));
				while (q.size() < lim) add_piece(q);
				while (q.size() > lim) void'(q.pop_back());
			end
			repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(0, 255)));
			send_bytes(q);
			random_bytes += q.size();
		end
		no_stall = 1'b0;

		// long runs until one passes the top of memory
		configure(1'b1, 16'($urandom_range(300, 400)), 3'($urandom_range(0, 7)));
		q.delete();
		repeat (64) begin
			q.push_back(ESC_BYTE);
			q.push_back(ESC_BYTE);
			q.push_back(8'hFF);
			q.push_back(8'($urandom_range(0, 255)));
		end
		q.push_back(ESC_BYTE);
		q.push_back(ESC_BYTE);
		q.push_back(8'($urandom_range(8'h41, 8'hFF)));
		q.push_back(8'($urandom_range(0, 255)));
		q.push_back(8'($urandom_range(0, 255)));
		send_bytes(q);

		// zero count run that closes the block
		configure(1'b1, 16'd4, 3'($urandom_range(0, 7)));
		q = '{ESC_BYTE, ESC_BYTE, 8'h00, 8'($urandom_range(0, 255))};
		send_bytes(q);

		// start of a raw bank: every byte a literal, escapes included
		no_stall = 1'b1;
		configure(1'b1, RAW_LENGTH, 3'd7);
		q.delete();
		repeat (RAW_BYTES) begin
			if ($urandom_range(0, 9) < 3) q.push_back(ESC_BYTE);
			else q.push_back(8'($urandom_range(0, 255)));
		end
		send_bytes(q);
		no_stall = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		$display("%0d bytes sent over %0d register phases, %0d register writes, %0d runs checked",
			bytes_sent, phases, reg_writes, book.checked);
		$display("covered marker streams, bounded blocks, empty block, overflow and raw bank start");
		if (book.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
